[hw/rtl/lstp_pkg.sv]
// ----------------------------------------------------------------------------
// lstp_pkg
// Shared widths, constants and codes for the LFO symmetry timer period block.
// ----------------------------------------------------------------------------
`default_nettype none

package lstp_pkg;

    // Wavetable geometry
    localparam int TABLE_LENGTH = 512;
    localparam int IDX_W        = 9;
    localparam int QUARTER      = TABLE_LENGTH / 4;
    localparam int HALF         = TABLE_LENGTH / 2;
    localparam int THREE_QTR    = (TABLE_LENGTH / 4) * 3;

    // Field widths
    localparam int SHAPE_W   = 2;
    localparam int BYTE_W    = 8;
    localparam int PRESC_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int START_W   = 9;
    localparam int OPRESC_W  = 13;
    localparam int PERIOD_W  = 9;

    // Symmetry pot and timer constants
    localparam logic [BYTE_W-1:0]   ADC_HALF    = 8'd128;
    localparam logic [PERIOD_W-1:0] TIMER_SPAN  = 9'd256;
    localparam logic [PERIOD_W:0]   TIMER_SPANW = 10'd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SHAPE   = 2'd0,
        CFG_BASE_START   = 2'd1,
        CFG_BASE_PRESC   = 2'd2,
        CFG_SYMMETRY_POT = 2'd3
    } t_cfg_index;

    // Wave shapes
    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SQUARE   = 2'd2,
        SHAPE_OTHER    = 2'd3
    } t_wave_shape;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0]  RST_BASE_START = 8'd0;
    localparam logic [PRESC_W-1:0] RST_BASE_PRESC = 12'd64;
    localparam logic [BYTE_W-1:0]  RST_POT        = 8'd0;

endpackage

`default_nettype wire

[hw/rtl/lfo_symmetry_timer_period.sv]
// ----------------------------------------------------------------------------
// lfo_symmetry_timer_period
// Per-step timer reload and prescaler for an LFO with symmetry adjustment.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  ------    ---------  ------------------------  --------------------------------
//  in        sink       i_in_valid / o_in_stall   i_table_index
//  out       source     o_out_valid / i_out_stall o_timer_start, o_timer_prescaler,
//                                                 o_shortened_period,
//                                                 o_lengthened_period,
//                                                 o_prescaler_doubled
//  cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while the output is not stalled; the
//  index is held in the input register, then the result in the result
//  register, where it stays valid until it is taken.
//  The 9x7 multiply of the reload period by the symmetry correction and the
//  rounding compares sit in the single stage between the two registers.
//  Synchronous active-low reset clears the valid flags, quadrant state and
//  configuration registers to their defaults.
//  A stall on the output holds the result register; the input stalls only
//  when both registers are full and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_symmetry_timer_period
    import lstp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,

    // input request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [IDX_W-1:0]      i_table_index,

    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [START_W-1:0]         o_timer_start,
    output logic [OPRESC_W-1:0]        o_timer_prescaler,
    output logic [PERIOD_W-1:0]        o_shortened_period,
    output logic [PERIOD_W-1:0]        o_lengthened_period,
    output logic                       o_prescaler_doubled
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_wave_shape        r_wave_shape;
    logic [BYTE_W-1:0]  r_base_start;
    logic [PRESC_W-1:0] r_base_presc;
    logic [BYTE_W-1:0]  r_symmetry_pot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape   <= SHAPE_SQUARE;
            r_base_start   <= RST_BASE_START;
            r_base_presc   <= RST_BASE_PRESC;
            r_symmetry_pot <= RST_POT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WAVE_SHAPE:   r_wave_shape   <= t_wave_shape'(i_cfg_data[SHAPE_W-1:0]);
                CFG_BASE_START:   r_base_start   <= i_cfg_data[BYTE_W-1:0];
                CFG_BASE_PRESC:   r_base_presc   <= i_cfg_data[PRESC_W-1:0];
                CFG_SYMMETRY_POT: r_symmetry_pot <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_out_valid;
    logic             out_ready;
    logic             in_accept;
    logic             s1_advance;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // index needs no reset: only read while r_s1_valid is set
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx <= i_table_index;
        end
    end

    // ------------------------------------------------------------------
    // Quadrant / half-cycle tracking
    // ------------------------------------------------------------------
    logic             r_quad_second;
    logic             r_half_second;
    logic             n_quad_second;
    logic             n_half_second;
    logic [IDX_W-1:0] idx;

    always_comb begin
        // an index equal to the table length wraps to zero
        if ((IDX_W+1)'(r_s1_idx) == (IDX_W+1)'(TABLE_LENGTH)) begin
            idx = '0;
        end else begin
            idx = r_s1_idx;
        end
        n_quad_second = r_quad_second;
        n_half_second = r_half_second;
        // hold the state between quarter boundaries
        if (idx == '0) begin
            n_quad_second = 1'b0;
            n_half_second = 1'b0;
        end else if (idx == IDX_W'(QUARTER)) begin
            n_quad_second = 1'b1;
            n_half_second = 1'b0;
        end else if (idx == IDX_W'(HALF)) begin
            n_quad_second = 1'b0;
            n_half_second = 1'b1;
        end else if (idx == IDX_W'(THREE_QTR)) begin
            n_quad_second = 1'b1;
            n_half_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_second <= 1'b0;
            r_half_second <= 1'b0;
        end else if (s1_advance) begin
            r_quad_second <= n_quad_second;
            r_half_second <= n_half_second;
        end
    end

    // ------------------------------------------------------------------
    // Period correction
    // ------------------------------------------------------------------
    logic                cw;
    logic                lengthen;
    logic [6:0]          prc;
    logic [PERIOD_W-1:0] d;
    logic [15:0]         prod;
    logic [BYTE_W-1:0]   s;
    logic [BYTE_W-1:0]   r;
    logic [PERIOD_W:0]   shorten;
    logic [PERIOD_W:0]   longer;
    logic [PERIOD_W:0]   start;
    logic                dither;
    logic                doubled;
    logic                odd;

    always_comb begin
        cw = (r_symmetry_pot < ADC_HALF);

        // pick the lengthening half of the cycle from shape and direction
        unique case (r_wave_shape)
            SHAPE_SINE, SHAPE_TRIANGLE: begin
                lengthen = (n_quad_second == n_half_second) ? cw : !cw;
            end
            SHAPE_SQUARE: begin
                lengthen = !n_half_second ? cw : !cw;
            end
            default: begin
                lengthen = 1'b0;
            end
        endcase

        // clockwise: 127 - pot; counter-clockwise: pot - 128
        prc  = cw ? ~r_symmetry_pot[6:0] : r_symmetry_pot[6:0];
        d    = TIMER_SPAN - PERIOD_W'(r_base_start);
        prod = 16'(d) * 16'(prc);
        s    = prod[15:8];
        r    = prod[7:0];

        shorten = (PERIOD_W+1)'(d) - (PERIOD_W+1)'(s);
        longer  = (PERIOD_W+1)'(d) + (PERIOD_W+1)'(s);
        dither  = 1'b0;
        doubled = 1'b0;
        odd     = 1'b0;

        if (longer < TIMER_SPANW || (longer == TIMER_SPANW && r == '0)) begin
            // fits the timer: round above half, dither at exactly half
            if (r == ADC_HALF) begin
                dither = 1'b1;
            end else if (r > ADC_HALF) begin
                shorten = shorten - (PERIOD_W+1)'(1);
                longer  = longer + (PERIOD_W+1)'(1);
            end
        end else begin
            // too long: halve the period, double the prescaler when lengthening
            if (r >= ADC_HALF) begin
                shorten = shorten - (PERIOD_W+1)'(1);
                longer  = longer + (PERIOD_W+1)'(1);
            end
            odd    = longer[0];
            longer = {1'b0, longer[PERIOD_W:1]};
            if (lengthen) begin
                doubled = 1'b1;
                dither  = odd;
            end
        end

        // odd indices take the dithered neighbor
        if (lengthen) begin
            if (dither && idx[0]) begin
                start = TIMER_SPANW - (longer + (PERIOD_W+1)'(1));
            end else begin
                start = TIMER_SPANW - longer;
            end
        end else begin
            if (dither && idx[0]) begin
                start = TIMER_SPANW - (shorten - (PERIOD_W+1)'(1));
            end else begin
                start = TIMER_SPANW - shorten;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            o_timer_start       <= start[START_W-1:0];
            o_timer_prescaler   <= doubled ? {r_base_presc, 1'b0} : {1'b0, r_base_presc};
            o_shortened_period  <= shorten[PERIOD_W-1:0];
            o_lengthened_period <= longer[PERIOD_W-1:0];
            o_prescaler_doubled <= doubled;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/lstp_checker.sv]
// ----------------------------------------------------------------------------
// lstp_checker
// Port-level assertions for the LFO symmetry timer period block.
// ----------------------------------------------------------------------------
`default_nettype none

module lstp_checker
    import lstp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [START_W-1:0]   o_timer_start,
    input wire logic [OPRESC_W-1:0]  o_timer_prescaler,
    input wire logic [PERIOD_W-1:0]  o_shortened_period,
    input wire logic [PERIOD_W-1:0]  o_lengthened_period,
    input wire logic                 o_prescaler_doubled
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_timer_start)
            && $stable(o_timer_prescaler) && $stable(o_shortened_period)
            && $stable(o_lengthened_period) && $stable(o_prescaler_doubled))
        else $error("stalled result changed");

    // input backs up only behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a doubled prescaler is even and goes with a halved period
    a_doubled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_prescaler_doubled |->
            !o_timer_prescaler[0] && o_lengthened_period <= PERIOD_W'(192))
        else $error("doubled prescaler inconsistent");

endmodule

bind lfo_symmetry_timer_period lstp_checker u_lstp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_timer_start       (o_timer_start),
    .o_timer_prescaler   (o_timer_prescaler),
    .o_shortened_period  (o_shortened_period),
    .o_lengthened_period (o_lengthened_period),
    .o_prescaler_doubled (o_prescaler_doubled)
);

`default_nettype wire

[test/lfo_symmetry_timer_period_test.sv]
// ----------------------------------------------------------------------------
// lfo_symmetry_timer_period_test
// Self-checking bench: drives wavetable indexes under several register
// settings, predicts each timer setting and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_symmetry_timer_period_test;
    import lstp_pkg::*;

    localparam int SETTLE_CYCLES  = 4;     // two pipeline registers plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int RANDOM_ITEMS   = 730;

    // One timer setting, in output port order
    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [OPRESC_W-1:0] presc;
        logic [PERIOD_W-1:0] shorter;
        logic [PERIOD_W-1:0] longer;
        logic                doubled;
    } t_timer_setting;

    // ------------------------------------------------------------------------
    // Timer setting scoreboard: own copy of the registers and the quadrant
    // state, plus the queue of settings still owed by the block.
    // ------------------------------------------------------------------------
    class t_timer_scoreboard;
        t_wave_shape          shape;
        logic [BYTE_W-1:0]    base_start;
        logic [PRESC_W-1:0]   base_presc;
        logic [BYTE_W-1:0]    pot;
        bit                   quad_second;
        bit                   half_second;
        t_timer_setting       owed_q[$];
        int                   errors;

        function new();
            shape       = SHAPE_SQUARE;
            base_start  = RST_BASE_START;
            base_presc  = RST_BASE_PRESC;
            pot         = RST_POT;
            quad_second = 1'b0;
            half_second = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_index which, logic [CFG_DAT_W-1:0] value);
            case (which)
                CFG_WAVE_SHAPE:   shape      = t_wave_shape'(value[SHAPE_W-1:0]);
                CFG_BASE_START:   base_start = value[BYTE_W-1:0];
                CFG_BASE_PRESC:   base_presc = value[PRESC_W-1:0];
                CFG_SYMMETRY_POT: pot        = value[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function int owed_count();
            return owed_q.size();
        endfunction

        // Advance the quadrant state and work out the timer setting.
        function void note_request(logic [IDX_W-1:0] index);
            t_timer_setting want;
            bit             cw, lengthen, dither, doubled, odd;
            int             span, corr, prod, whole, frac;
            int             shorter, longer, start, presc;
            dither  = 1'b0;
            doubled = 1'b0;

            if (index == 0) begin
                quad_second = 1'b0; half_second = 1'b0;
            end else if (index == QUARTER) begin
                quad_second = 1'b1; half_second = 1'b0;
            end else if (index == HALF) begin
                quad_second = 1'b0; half_second = 1'b1;
            end else if (index == THREE_QTR) begin
                quad_second = 1'b1; half_second = 1'b1;
            end

            cw = (pot < ADC_HALF);
            case (shape)
                SHAPE_SINE, SHAPE_TRIANGLE: begin
                    lengthen = (quad_second == half_second) ? cw : !cw;
                end
                SHAPE_SQUARE: begin
                    lengthen = half_second ? !cw : cw;
                end
                default: begin
                    lengthen = 1'b0;
                end
            endcase

            corr  = cw ? (int'(ADC_HALF) - 1 - int'(pot)) : (int'(pot) - int'(ADC_HALF));
            span  = int'(TIMER_SPAN) - int'(base_start);
            prod  = (span * corr) & 16'hFFFF;
            whole = prod >> BYTE_W;
            frac  = prod & 8'hFF;
            shorter = span - whole;
            longer  = span + whole;

            if (longer < int'(TIMER_SPAN) || (longer == int'(TIMER_SPAN) && frac == 0)) begin
                // fits the timer: round above half, dither on odd indexes at an exact half step
                if (frac == int'(ADC_HALF)) begin
                    dither = 1'b1;
                end else if (frac > int'(ADC_HALF)) begin
                    shorter = shorter - 1;
                    longer  = longer + 1;
                end
            end else begin
                // too long for the timer: halve, double the prescaler when lengthening
                if (frac >= int'(ADC_HALF)) begin
                    shorter = shorter - 1;
                    longer  = longer + 1;
                end
                odd    = longer[0];
                longer = longer >> 1;
                if (lengthen) begin
                    doubled = 1'b1;
                    dither  = odd;
                end
            end

            if (lengthen) begin
                start = int'(TIMER_SPAN) - longer - ((dither && index[0]) ? 1 : 0);
            end else begin
                start = int'(TIMER_SPAN) - shorter + ((dither && index[0]) ? 1 : 0);
            end
            presc = doubled ? int'(base_presc) * 2 : int'(base_presc);

            want.start   = start[START_W-1:0];
            want.presc   = presc[OPRESC_W-1:0];
            want.shorter = shorter[PERIOD_W-1:0];
            want.longer  = longer[PERIOD_W-1:0];
            want.doubled = doubled;
            owed_q.push_back(want);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(t_timer_setting got);
            t_timer_setting want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with nothing owed, start %0d", got.start));
                return;
            end
            want = owed_q.pop_front();
            if (got.start !== want.start)
                report($sformatf("timer_start %0d, want %0d", got.start, want.start));
            if (got.presc !== want.presc)
                report($sformatf("timer_prescaler %0d, want %0d", got.presc, want.presc));
            if (got.shorter !== want.shorter)
                report($sformatf("shortened_period %0d, want %0d",
                                 got.shorter, want.shorter));
            if (got.longer !== want.longer)
                report($sformatf("lengthened_period %0d, want %0d",
                                 got.longer, want.longer));
            if (got.doubled !== want.doubled)
                report($sformatf("prescaler_doubled %0b, want %0b",
                                 got.doubled, want.doubled));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IDX_W-1:0]      i_table_index;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [START_W-1:0]    o_timer_start;
    logic [OPRESC_W-1:0]   o_timer_prescaler;
    logic [PERIOD_W-1:0]   o_shortened_period;
    logic [PERIOD_W-1:0]   o_lengthened_period;
    logic                  o_prescaler_doubled;

    lfo_symmetry_timer_period dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_table_index       (i_table_index),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_timer_start       (o_timer_start),
        .o_timer_prescaler   (o_timer_prescaler),
        .o_shortened_period  (o_shortened_period),
        .o_lengthened_period (o_lengthened_period),
        .o_prescaler_doubled (o_prescaler_doubled)
    );

    t_timer_scoreboard sb;
    bit                gaps_on = 1'b1;
    int                burst_left = 1;
    int                idle_cycles = 0;
    int                stall_mode = 0;
    int                stall_left = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes before this edge's updates land, feed
    // the scoreboard, and watch for a hang.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_table_index);
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_timer_start, o_timer_prescaler, o_shortened_period,
                                 o_lengthened_period, o_prescaler_doubled});
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: switch at random intervals between stall patterns -
    // free running, random, long periodic stalls, and mostly stalled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            2:       i_out_stall <= ((stall_left % 32) < 20);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Present one request and hold it until accepted; then maybe open a gap
    // at the end of a burst.
    task automatic send_request(logic [IDX_W-1:0] index);
        i_in_valid    <= 1'b1;
        i_table_index <= index;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and hold off until every owed result is back, then let the
    // pipeline settle. Wait for an edge first so the monitor has noted a
    // request accepted at the edge just passed.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_count() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_cycle(t_cfg_index which, logic [CFG_DAT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(which, value);
    endtask

    // Write all four registers one after another; block must be idle.
    task automatic write_settings(t_wave_shape shape, logic [BYTE_W-1:0] start,
                                  logic [PRESC_W-1:0] presc, logic [BYTE_W-1:0] pot);
        cfg_cycle(CFG_WAVE_SHAPE, CFG_DAT_W'(shape));
        cfg_cycle(CFG_BASE_START, CFG_DAT_W'(start));
        cfg_cycle(CFG_BASE_PRESC, CFG_DAT_W'(presc));
        cfg_cycle(CFG_SYMMETRY_POT, CFG_DAT_W'(pot));
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                 sweep_reset[$]  = '{0, 1, 128, 129, 256, 257, 384, 385, 511};
        int                 sweep_dither[$] = '{3, 4, 128, 131, 256, 257};
        int                 sweep_other[$]  = '{0, 510, 511};
        int                 sweep_flat[$]   = '{384, 385, 0};
        int                 sent, phase_len, step, pos, phase_no;
        t_wave_shape        r_shape;
        logic [BYTE_W-1:0]  r_start, r_pot;
        logic [PRESC_W-1:0] r_presc;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_WAVE_SHAPE;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_table_index <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: square wave, full period, maximum clockwise pot.
        // The lengthened period overflows, so it is halved and dithered.
        foreach (sweep_reset[k])
            send_request(IDX_W'(sweep_reset[k]));

        // Half-step remainder: odd indexes dither; zero prescaler passes through
        wait_drained();
        write_settings(SHAPE_SINE, 8'd128, 12'd0, 8'd126);
        foreach (sweep_dither[k])
            send_request(IDX_W'(sweep_dither[k]));

        // Other shape always shortens; shortest period, widest prescaler
        wait_drained();
        write_settings(SHAPE_OTHER, 8'd255, 12'd4095, 8'd255);
        foreach (sweep_other[k])
            send_request(IDX_W'(sweep_other[k]));

        // Pot at center: no correction at all
        wait_drained();
        write_settings(SHAPE_TRIANGLE, 8'd1, 12'd2048, 8'd128);
        foreach (sweep_flat[k])
            send_request(IDX_W'(sweep_flat[k]));

        // Random phases: mostly stepping through the table so the quadrant
        // boundaries come round, with random jumps mixed in.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            r_shape = t_wave_shape'($urandom_range(0, 3));
            r_start = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                  : BYTE_W'($urandom);
            case ($urandom_range(0, 5))
                0:       r_presc = 12'd0;
                1:       r_presc = 12'd4095;
                2:       r_presc = 12'd1;
                default: r_presc = PRESC_W'($urandom);
            endcase
            case ($urandom_range(0, 6))
                0:       r_pot = 8'd0;
                1:       r_pot = 8'd127;
                2:       r_pot = 8'd128;
                3:       r_pot = 8'd255;
                default: r_pot = BYTE_W'($urandom);
            endcase
            write_settings(r_shape, r_start, r_presc, r_pot);

            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 5))
                0:       step = 1;
                1:       step = 2;
                2:       step = 8;
                3:       step = 32;
                default: step = $urandom_range(1, 64);
            endcase
            pos = $urandom_range(0, TABLE_LENGTH - 1);
            for (int n = 0; n < phase_len; n++) begin
                // once, hold the sender mid-phase until the block has emptied
                if (phase_no == 1 && n == phase_len / 2)
                    wait_drained();
                if ($urandom_range(0, 4) == 0)
                    pos = $urandom_range(0, TABLE_LENGTH - 1);
                else
                    pos = (pos + step) % TABLE_LENGTH;
                send_request(pos[IDX_W-1:0]);
            end
            sent     = sent + phase_len;
            phase_no = phase_no + 1;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.owed_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_count()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
